/* src/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

    localparam int MaxFrameDefault = 72;

    localparam logic [7:0] HdrByte      = 8'h2A;
    localparam logic [7:0] AckBit       = 8'h80;
    localparam logic [7:0] InstrMask    = 8'h7F;
    localparam logic [7:0] TempInstr    = 8'h13;
    localparam logic [7:0] TempSub      = 8'h01;
    localparam logic [7:0] AbandonReset = 8'd120;

    localparam logic       OpByte = 1'b0;
    localparam logic       OpTick = 1'b1;

    // byte positions inside a frame
    localparam int PosIdle  = 0;
    localparam int PosHdr2  = 1;
    localparam int PosLen   = 2;
    localparam int PosInstr = 3;
    localparam int PosParm1 = 4;
    localparam int PosParm2 = 5;

    localparam int HdrOverhead = 4;
    localparam int SumOffset   = 3;

    typedef struct packed {
        logic       frame_done;
        logic       checksum_ok;
        logic       is_ack;
        logic [6:0] ack_instr;
        logic [7:0] ack_param;
        logic       is_temp;
        logic [7:0] temp_code;
        logic [6:0] payload_len;
        logic       dropped;
        logic       link_alive;
    } t_result;

endpackage

`default_nettype wire

/* src/cfr_if.sv */
// ----------------------------------------------------------------------------
// cfr_if
// Handshake channels of the checksummed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] byte_value;

    modport source (output valid, output opcode, output byte_value, input ready);
    modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

interface cfr_out_if;
    logic       valid;
    logic       ready;
    logic       frame_done;
    logic       checksum_ok;
    logic       is_ack;
    logic [6:0] ack_instr;
    logic [7:0] ack_param;
    logic       is_temp;
    logic [7:0] temp_code;
    logic [6:0] payload_len;
    logic       dropped;
    logic       link_alive;

    modport source (
        output valid, input ready,
        output frame_done, output checksum_ok, output is_ack, output ack_instr,
        output ack_param, output is_temp, output temp_code, output payload_len,
        output dropped, output link_alive
    );
    modport sink (
        input valid, output ready,
        input frame_done, input checksum_ok, input is_ack, input ack_instr,
        input ack_param, input is_temp, input temp_code, input payload_len,
        input dropped, input link_alive
    );
endinterface

interface cfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] abandon_ticks;

    modport source (output valid, output abandon_ticks, input ready);
    modport sink   (input valid, input abandon_ticks, output ready);
endinterface

`default_nettype wire

/* src/checksummed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Finds 2A 2A LEN payload CS frames in a byte stream, checks the additive
// checksum and classes valid frames as acknowledge or temperature report.
//
//   port    dir   payload                         transfer when
//   i_rx    in    opcode, byte_value              valid && ready
//   o_res   out   frame_done .. link_alive        valid && ready
//   i_cfg   in    abandon_ticks                   valid && ready (always ready)
//
// One item per cycle while the result is not stalled; an item passes through
// the input register, then the frame logic into the result register.
// i_rst_n is synchronous, active low; it clears frame state and sets
// abandon_ticks to 120. A stalled result holds the input register; input
// ready falls only when both registers are full and o_res.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module checksummed_frame_receiver #(
    parameter int MAX_FRAME = cfr_pkg::MaxFrameDefault
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cfr_in_if.sink     i_rx,
    cfr_out_if.source  o_res,
    cfr_cfg_if.sink    i_cfg
);

    logic             r_in_valid;
    logic             r_in_opcode;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    cfr_pkg::t_result r_out;
    logic [7:0]       r_abandon_ticks;

    logic             advance;
    cfr_pkg::t_result parse_res;

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    cfr_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_opcode        (r_in_opcode),
        .i_byte_value    (r_in_byte),
        .i_abandon_ticks (r_abandon_ticks),
        .o_result        (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_abandon_ticks <= cfr_pkg::AbandonReset;
        end else begin
            if (i_cfg.valid) begin
                r_abandon_ticks <= i_cfg.abandon_ticks;
            end
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_opcode <= i_rx.opcode;
            r_in_byte   <= i_rx.byte_value;
        end
        if (advance) begin
            r_out <= parse_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.frame_done  = r_out.frame_done;
    assign o_res.checksum_ok = r_out.checksum_ok;
    assign o_res.is_ack      = r_out.is_ack;
    assign o_res.ack_instr   = r_out.ack_instr;
    assign o_res.ack_param   = r_out.ack_param;
    assign o_res.is_temp     = r_out.is_temp;
    assign o_res.temp_code   = r_out.temp_code;
    assign o_res.payload_len = r_out.payload_len;
    assign o_res.dropped     = r_out.dropped;
    assign o_res.link_alive  = r_out.link_alive;

    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.checksum_ok |-> r_out.frame_done && r_out.link_alive)
        else $error("checksum_ok without a completed frame or alive flag");

    a_class_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.is_ack && r_out.is_temp) &&
                        !(r_out.frame_done && r_out.dropped))
        else $error("conflicting result classes");

    a_class_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.is_ack || r_out.is_temp) |-> r_out.checksum_ok)
        else $error("classified frame without valid checksum");

    a_alive_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_out_valid && r_out.link_alive |=> r_out.link_alive)
        else $error("link alive flag cleared");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule

`default_nettype wire

/* src/cfr_parser.sv */
// ----------------------------------------------------------------------------
// cfr_parser
// Frame state, running checksum and classification for one item per cycle while i_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_parser #(
    parameter int MAX_FRAME = cfr_pkg::MaxFrameDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_opcode,
    input  wire logic [7:0]      i_byte_value,
    input  wire logic [7:0]      i_abandon_ticks,
    output cfr_pkg::t_result     o_result
);

    localparam int PosW = $clog2(MAX_FRAME);

    logic [PosW-1:0] r_pos,    n_pos;
    logic [7:0]      r_len,    n_len;
    logic [7:0]      r_sum,    n_sum;
    logic [7:0]      r_instr,  n_instr;
    logic [7:0]      r_parm1,  n_parm1;
    logic [7:0]      r_parm2,  n_parm2;
    logic [7:0]      r_idle,   n_idle;
    logic            r_alive,  n_alive;

    logic [8:0]      tick_cnt;
    logic            at_end;
    cfr_pkg::t_result res;

    assign tick_cnt = {1'b0, r_idle} + 9'd1;
    assign at_end   = {{(9-PosW){1'b0}}, r_pos} >=
                      ({1'b0, r_len} + 9'(cfr_pkg::SumOffset));

    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum   = r_sum;
        n_instr = r_instr;
        n_parm1 = r_parm1;
        n_parm2 = r_parm2;
        n_idle  = r_idle;
        n_alive = r_alive;
        res     = '0;

        if (i_opcode == cfr_pkg::OpTick) begin
            if (r_pos != PosW'(cfr_pkg::PosIdle)) begin
                if (tick_cnt > {1'b0, i_abandon_ticks}) begin
                    n_pos       = PosW'(cfr_pkg::PosIdle);
                    n_idle      = '0;
                    res.dropped = 1'b1;
                end else begin
                    n_idle = tick_cnt[7:0];
                end
            end else begin
                n_idle = '0;
            end
        end else begin
            n_idle = '0;
            if (r_pos == PosW'(cfr_pkg::PosIdle)) begin
                if (i_byte_value == cfr_pkg::HdrByte) begin
                    n_pos = PosW'(cfr_pkg::PosHdr2);
                end
            end else if (r_pos == PosW'(cfr_pkg::PosHdr2)) begin
                n_pos = (i_byte_value == cfr_pkg::HdrByte) ? PosW'(cfr_pkg::PosLen)
                                                           : PosW'(cfr_pkg::PosIdle);
            end else if (r_pos == PosW'(cfr_pkg::PosLen)) begin
                n_len = i_byte_value;
                n_sum = i_byte_value;
                if (({1'b0, i_byte_value} + 9'(cfr_pkg::HdrOverhead)) > 9'(MAX_FRAME)) begin
                    n_pos       = PosW'(cfr_pkg::PosIdle);
                    res.dropped = 1'b1;
                end else begin
                    n_pos = PosW'(cfr_pkg::PosInstr);
                end
            end else if (at_end) begin
                res.frame_done  = 1'b1;
                res.payload_len = r_len[6:0];
                if (r_sum == i_byte_value) begin
                    res.checksum_ok = 1'b1;
                    n_alive         = 1'b1;
                    if ((r_len >= 8'd2) && ((r_instr & cfr_pkg::AckBit) != 8'd0)) begin
                        res.is_ack    = 1'b1;
                        res.ack_instr = r_instr[6:0] & cfr_pkg::InstrMask[6:0];
                        res.ack_param = r_parm1;
                    end else if ((r_len >= 8'd3) && (r_instr == cfr_pkg::TempInstr) &&
                                 (r_parm1 == cfr_pkg::TempSub)) begin
                        res.is_temp   = 1'b1;
                        res.temp_code = r_parm2;
                    end
                end
                n_pos = PosW'(cfr_pkg::PosIdle);
            end else begin
                if (r_pos == PosW'(cfr_pkg::PosInstr)) begin
                    n_instr = i_byte_value;
                end else if (r_pos == PosW'(cfr_pkg::PosParm1)) begin
                    n_parm1 = i_byte_value;
                end else if (r_pos == PosW'(cfr_pkg::PosParm2)) begin
                    n_parm2 = i_byte_value;
                end
                n_sum = r_sum + i_byte_value;
                n_pos = r_pos + PosW'(1);
            end
        end
        res.link_alive = n_alive;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_sum   <= '0;
            r_instr <= '0;
            r_parm1 <= '0;
            r_parm2 <= '0;
            r_idle  <= '0;
            r_alive <= 1'b0;
        end else if (i_en) begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_instr <= n_instr;
            r_parm1 <= n_parm1;
            r_parm2 <= n_parm2;
            r_idle  <= n_idle;
            r_alive <= n_alive;
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for checksummed_frame_receiver. A scoreboard class
// tracks the frame state machine, predicts one report per accepted byte or
// tick and compares every output report field by field. Stimulus is a short
// directed pass followed by random frames, noise and tick runs over several
// abandon_ticks settings. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int MaxFrame   = cfr_pkg::MaxFrameDefault;
    localparam int CycleLimit = 200000;

    class frame_checker;
        logic [6:0] pos;
        logic [7:0] len_byte;
        logic [7:0] run_sum;
        logic [7:0] instr;
        logic [7:0] parm1;
        logic [7:0] parm2;
        logic [7:0] idle_cnt;
        logic [7:0] abandon;
        logic       alive;
        cfr_pkg::t_result pending_reports[$];
        int         mismatches;

        function new();
            pos        = '0;
            len_byte   = '0;
            run_sum    = '0;
            instr      = '0;
            parm1      = '0;
            parm2      = '0;
            idle_cnt   = '0;
            abandon    = cfr_pkg::AbandonReset;
            alive      = 1'b0;
            mismatches = 0;
        endfunction

        function void set_abandon(logic [7:0] v);
            abandon = v;
        endfunction

        function void predict_item(logic op, logic [7:0] b);
            cfr_pkg::t_result r;
            logic [8:0]       t;
            r = '0;
            if (op == cfr_pkg::OpTick) begin
                if (int'(pos) != cfr_pkg::PosIdle) begin
                    t = {1'b0, idle_cnt} + 9'd1;
                    if (t > {1'b0, abandon}) begin
                        pos       = 7'(cfr_pkg::PosIdle);
                        idle_cnt  = '0;
                        r.dropped = 1'b1;
                    end else begin
                        idle_cnt = t[7:0];
                    end
                end else begin
                    idle_cnt = '0;
                end
            end else begin
                idle_cnt = '0;
                if (int'(pos) == cfr_pkg::PosIdle) begin
                    if (b == cfr_pkg::HdrByte) pos = 7'(cfr_pkg::PosHdr2);
                end else if (int'(pos) == cfr_pkg::PosHdr2) begin
                    pos = (b == cfr_pkg::HdrByte) ? 7'(cfr_pkg::PosLen)
                                                  : 7'(cfr_pkg::PosIdle);
                end else if (int'(pos) == cfr_pkg::PosLen) begin
                    len_byte = b;
                    run_sum  = b;
                    if (int'(b) + cfr_pkg::HdrOverhead > MaxFrame) begin
                        pos       = 7'(cfr_pkg::PosIdle);
                        r.dropped = 1'b1;
                    end else begin
                        pos = 7'(cfr_pkg::PosInstr);
                    end
                end else if (int'(pos) >= int'(len_byte) + cfr_pkg::SumOffset) begin
                    r.frame_done  = 1'b1;
                    r.payload_len = len_byte[6:0];
                    if (run_sum == b) begin
                        r.checksum_ok = 1'b1;
                        alive         = 1'b1;
                        if (len_byte >= 8'd2 && (instr & cfr_pkg::AckBit) != 8'd0) begin
                            r.is_ack    = 1'b1;
                            r.ack_instr = 7'(instr & cfr_pkg::InstrMask);
                            r.ack_param = parm1;
                        end else if (len_byte >= 8'd3 && instr == cfr_pkg::TempInstr &&
                                     parm1 == cfr_pkg::TempSub) begin
                            r.is_temp   = 1'b1;
                            r.temp_code = parm2;
                        end
                    end
                    pos = 7'(cfr_pkg::PosIdle);
                end else begin
                    if (int'(pos) == cfr_pkg::PosInstr) instr = b;
                    else if (int'(pos) == cfr_pkg::PosParm1) parm1 = b;
                    else if (int'(pos) == cfr_pkg::PosParm2) parm2 = b;
                    run_sum = run_sum + b;
                    pos     = pos + 7'd1;
                end
            end
            r.link_alive = alive;
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string name, int want, int seen);
            if (want != seen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %s: expected %0d actual %0d", name, want, seen);
            end
        endfunction

        function void check_report(cfr_pkg::t_result got);
            cfr_pkg::t_result want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: actual %h", got);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("frame_done", want.frame_done, got.frame_done);
            compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
            compare_field("is_ack", want.is_ack, got.is_ack);
            compare_field("ack_instr", want.ack_instr, got.ack_instr);
            compare_field("ack_param", want.ack_param, got.ack_param);
            compare_field("is_temp", want.is_temp, got.is_temp);
            compare_field("temp_code", want.temp_code, got.temp_code);
            compare_field("payload_len", want.payload_len, got.payload_len);
            compare_field("dropped", want.dropped, got.dropped);
            compare_field("link_alive", want.link_alive, got.link_alive);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cfr_in_if  rx_ch ();
    cfr_out_if res_ch ();
    cfr_cfg_if cfg_ch ();

    checksummed_frame_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    frame_checker     chk;
    cfr_pkg::t_result seen_report;
    logic [7:0]       abandon_now;
    logic [7:0]       dir_q[$];
    int               sent_count;
    int               reports_seen;
    int               cycle_count;
    int               burst_left;

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        rx_ch.valid         = 1'b0;
        rx_ch.opcode        = cfr_pkg::OpByte;
        rx_ch.byte_value    = '0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.abandon_ticks = '0;
        sent_count          = 0;
        reports_seen        = 0;
        cycle_count         = 0;
        burst_left          = 1;
        abandon_now         = cfr_pkg::AbandonReset;
    end

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("checksummed_frame_receiver verification failed");
            $finish;
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen_report.frame_done  = res_ch.frame_done;
            seen_report.checksum_ok = res_ch.checksum_ok;
            seen_report.is_ack      = res_ch.is_ack;
            seen_report.ack_instr   = res_ch.ack_instr;
            seen_report.ack_param   = res_ch.ack_param;
            seen_report.is_temp     = res_ch.is_temp;
            seen_report.temp_code   = res_ch.temp_code;
            seen_report.payload_len = res_ch.payload_len;
            seen_report.dropped     = res_ch.dropped;
            seen_report.link_alive  = res_ch.link_alive;
            chk.check_report(seen_report);
            reports_seen++;
        end
    end

    // report sink with its own stall pattern and one long hold-off
    initial begin : report_sink
        int mode;
        int span;
        int hold_left;
        bit held;
        mode      = 0;
        span      = 0;
        hold_left = 0;
        held      = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && reports_seen >= 200) begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(10, 80);
                end
                span--;
                case (mode)
                    0: begin
                        res_ch.ready <= 1'b1;
                    end
                    1: begin
                        res_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        res_ch.ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic op, logic [7:0] b);
        int gap;
        rx_ch.valid      <= 1'b1;
        rx_ch.opcode     <= op;
        rx_ch.byte_value <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        chk.predict_item(op, b);
        sent_count++;
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
        end
    endtask

    task automatic send_tick();
        send_item(cfr_pkg::OpTick, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_queue();
        foreach (dir_q[i]) send_item(cfr_pkg::OpByte, dir_q[i]);
    endtask

    task automatic drain_reports();
        rx_ch.valid <= 1'b0;
        while (chk.pending_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_abandon(logic [7:0] v);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.abandon_ticks <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        chk.set_abandon(v);
        abandon_now = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic maybe_ticks();
        int n;
        if ($urandom_range(0, 11) != 0) return;
        if (abandon_now <= 8'd16 && $urandom_range(0, 1) == 1)
            n = int'(abandon_now) + $urandom_range(0, 1);
        else
            n = $urandom_range(1, 3);
        repeat (n) send_tick();
    endtask

    task automatic send_frame();
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] p;
        int r;
        int kind;
        r = $urandom_range(0, 99);
        if (r < 65)
            len = 8'($urandom_range(0, 6));
        else if (r < 85)
            len = 8'($urandom_range(7, MaxFrame - cfr_pkg::HdrOverhead - 1));
        else if (r < 92)
            len = 8'(MaxFrame - cfr_pkg::HdrOverhead);
        else
            len = 8'($urandom_range(MaxFrame - cfr_pkg::HdrOverhead + 1, 255));
        send_item(cfr_pkg::OpByte, cfr_pkg::HdrByte);
        send_item(cfr_pkg::OpByte, cfr_pkg::HdrByte);
        send_item(cfr_pkg::OpByte, len);
        if (int'(len) + cfr_pkg::HdrOverhead > MaxFrame) return;
        kind = $urandom_range(0, 3);
        sum  = len;
        for (int i = 0; i < int'(len); i++) begin
            p = 8'($urandom_range(0, 255));
            if (kind == 0 && i == 0) p[7] = 1'b1;
            if (kind == 1) begin
                if (i == 0) p = cfr_pkg::TempInstr;
                else if (i == 1) p = cfr_pkg::TempSub;
                else if (i == 2 && $urandom_range(0, 1) == 1) p = 8'($urandom_range(0, 4));
            end
            maybe_ticks();
            send_item(cfr_pkg::OpByte, p);
            sum = sum + p;
        end
        maybe_ticks();
        if ($urandom_range(0, 6) == 0) sum = sum ^ 8'($urandom_range(1, 255));
        send_item(cfr_pkg::OpByte, sum);
    endtask

    task automatic random_traffic(int n);
        int stop_at;
        int k;
        stop_at = sent_count + n;
        while (sent_count < stop_at) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                send_frame();
            end else if (k == 7) begin
                send_item(cfr_pkg::OpByte, 8'($urandom_range(0, 255)));
            end else if (k == 8) begin
                send_tick();
            end else begin
                // broken header
                send_item(cfr_pkg::OpByte, cfr_pkg::HdrByte);
                send_item(cfr_pkg::OpByte, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : stimulus
        chk = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: idle tick, extreme acknowledge, temperature report,
        // bad second header, empty frame, overlong length
        send_tick();
        dir_q = {cfr_pkg::HdrByte, cfr_pkg::HdrByte, 8'h02, 8'hFF, 8'hFF, 8'h00};
        send_queue();
        dir_q = {cfr_pkg::HdrByte, cfr_pkg::HdrByte, 8'h03, cfr_pkg::TempInstr,
                 cfr_pkg::TempSub, 8'h04, 8'h1B};
        send_queue();
        dir_q = {cfr_pkg::HdrByte, 8'h41, cfr_pkg::HdrByte, cfr_pkg::HdrByte,
                 8'h00, 8'h00};
        send_queue();
        dir_q = {cfr_pkg::HdrByte, cfr_pkg::HdrByte, 8'hFF};
        send_queue();
        random_traffic(35);
        drain_reports();

        // zero idle allowance: first tick drops a partial frame
        write_abandon(8'd0);
        send_item(cfr_pkg::OpByte, cfr_pkg::HdrByte);
        send_tick();
        dir_q = {cfr_pkg::HdrByte, cfr_pkg::HdrByte, 8'h01};
        send_queue();
        send_tick();
        random_traffic(60);
        drain_reports();

        // widest allowance: 255 ticks hold the frame, the next one drops it
        write_abandon(8'd255);
        dir_q = {cfr_pkg::HdrByte, cfr_pkg::HdrByte, 8'h05, 8'h81};
        send_queue();
        repeat (256) send_tick();
        random_traffic(60);
        drain_reports();

        write_abandon(8'd5);
        random_traffic(100);
        drain_reports();

        write_abandon(8'($urandom_range(1, 20)));
        random_traffic(80);
        drain_reports();

        repeat (10) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.pending_reports.size() == 0)
            $display("checksummed_frame_receiver verification clean");
        else
            $display("checksummed_frame_receiver verification failed");
        $finish;
    end

endmodule

`default_nettype wire
